/* src/stt_pkg.sv */
// Shared types, constants and keyword lookup for the source text tokenizer.
// Used by the top level and the checker.
package stt_pkg;

  localparam int MaxTokenLenDefault = 255;
  localparam int PositionBitsDefault = 16;
  localparam int QueueDepth = 8;

  localparam logic [5:0] KIND_ENDFILE = 6'd0;
  localparam logic [5:0] KIND_NEWLINE = 6'd1;
  localparam logic [5:0] KIND_INT     = 6'd2;
  localparam logic [5:0] KIND_FLOAT   = 6'd3;
  localparam logic [5:0] KIND_STRING  = 6'd4;
  localparam logic [5:0] KIND_IDENT   = 6'd5;
  localparam logic [5:0] KIND_NOT     = 6'd18;
  localparam logic [5:0] KIND_INCR    = 6'd24;
  localparam logic [5:0] KIND_PLUS    = 6'd25;
  localparam logic [5:0] KIND_DECR    = 6'd26;
  localparam logic [5:0] KIND_ARROW   = 6'd27;
  localparam logic [5:0] KIND_MINUS   = 6'd28;
  localparam logic [5:0] KIND_STAR    = 6'd29;
  localparam logic [5:0] KIND_SLASH   = 6'd30;
  localparam logic [5:0] KIND_PERCENT = 6'd31;
  localparam logic [5:0] KIND_EQ      = 6'd32;
  localparam logic [5:0] KIND_ASSIGN  = 6'd33;
  localparam logic [5:0] KIND_NE      = 6'd34;
  localparam logic [5:0] KIND_LE      = 6'd35;
  localparam logic [5:0] KIND_LT      = 6'd36;
  localparam logic [5:0] KIND_GE      = 6'd37;
  localparam logic [5:0] KIND_GT      = 6'd38;
  localparam logic [5:0] KIND_LPAREN  = 6'd39;
  localparam logic [5:0] KIND_RPAREN  = 6'd40;
  localparam logic [5:0] KIND_LBRACK  = 6'd41;
  localparam logic [5:0] KIND_RBRACK  = 6'd42;
  localparam logic [5:0] KIND_LBRACE  = 6'd43;
  localparam logic [5:0] KIND_RBRACE  = 6'd44;
  localparam logic [5:0] KIND_DOT     = 6'd45;
  localparam logic [5:0] KIND_COMMA   = 6'd46;
  localparam logic [5:0] KIND_COLON   = 6'd47;
  localparam logic [5:0] KIND_SEMI    = 6'd48;
  localparam logic [5:0] KIND_ERROR   = 6'd49;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_FLOAT      = 3'd1;
  localparam logic [2:0] ERR_ESCAPE     = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED   = 3'd3;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd4;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [2:0]  error_code;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [7:0]  value_length;
    logic        run_end;
  } tok_rec_t;

  function automatic logic [5:0] keyword_kind(input logic [63:0] w);
    logic [5:0] k;
    k = KIND_IDENT;
    if (w == 64'("id")) k = 6'd6;
    else if (w == 64'("const")) k = 6'd7;
    else if (w == 64'("ref")) k = 6'd8;
    else if (w == 64'("true")) k = 6'd9;
    else if (w == 64'("false")) k = 6'd9;
    else if (w == 64'("if")) k = 6'd10;
    else if (w == 64'("elif")) k = 6'd11;
    else if (w == 64'("else")) k = 6'd12;
    else if (w == 64'("function")) k = 6'd13;
    else if (w == 64'("return")) k = 6'd14;
    else if (w == 64'("and")) k = 6'd15;
    else if (w == 64'("or")) k = 6'd16;
    else if (w == 64'("xor")) k = 6'd17;
    else if (w == 64'("not")) k = 6'd18;
    else if (w == 64'("while")) k = 6'd19;
    else if (w == 64'("loop")) k = 6'd20;
    else if (w == 64'("break")) k = 6'd21;
    else if (w == 64'("continue")) k = 6'd22;
    else if (w == 64'("include")) k = 6'd23;
    return k;
  endfunction

  function automatic logic [5:0] single_op_kind(input logic [7:0] p);
    logic [5:0] k;
    case (p)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "=":     k = KIND_ASSIGN;
      "!":     k = KIND_NOT;
      "<":     k = KIND_LT;
      default: k = KIND_GT;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    logic [5:0] k;
    k = KIND_ENDFILE;
    if (p == "+" && c == "+") k = KIND_INCR;
    else if (p == "-" && c == "-") k = KIND_DECR;
    else if (p == "-" && c == ">") k = KIND_ARROW;
    else if (c == "=") begin
      if (p == "=") k = KIND_EQ;
      else if (p == "!") k = KIND_NE;
      else if (p == "<") k = KIND_LE;
      else if (p == ">") k = KIND_GE;
    end
    return k;
  endfunction

endpackage

/* src/stt_byte_if.sv */
// Input channel of the tokenizer: one source byte per item.
// Depends on nothing.
`default_nettype none
interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_byte;
  modport source (output valid, char_code, last_byte, input ready);
  modport sink (input valid, char_code, last_byte, output ready);
endinterface
`default_nettype wire

/* src/stt_token_if.sv */
// Output channel of the tokenizer: one token record per item.
// Depends on nothing.
`default_nettype none
interface stt_token_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [2:0]  error_code;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [7:0]  value_length;
  logic        run_end;
  modport source (output valid, token_kind, error_code, start_line, start_column,
                  value_length, run_end, input ready);
  modport sink (input valid, token_kind, error_code, start_line, start_column,
                value_length, run_end, output ready);
endinterface
`default_nettype wire

/* src/source_text_tokenizer.sv */
// Top level of the source text tokenizer: scanner state and record queue.
// Depends on stt_pkg, stt_byte_if and stt_token_if.
// Each record is written into the queue when its byte is accepted and is offered from the queue head.
// Throughput: one byte per cycle while the queue holds no more than five records;
// each byte yields zero to three records, drained one per cycle while the sink is ready.
// Reset (rst, synchronous): scanner idle, positions zero, queue empty.
`default_nettype none
module source_text_tokenizer #(
  parameter int MAX_TOKEN_LEN = stt_pkg::MaxTokenLenDefault,
  parameter int POSITION_BITS = stt_pkg::PositionBitsDefault
) (
  input wire logic     clk,
  input wire logic     rst,
  stt_byte_if.sink     bytes,
  stt_token_if.source  tokens
);
  import stt_pkg::*;

  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int PW = POSITION_BITS;
  localparam int QW = $clog2(QueueDepth);

  localparam logic [3:0] M_IDLE = 4'd0;
  localparam logic [3:0] M_WORD = 4'd1;
  localparam logic [3:0] M_INT  = 4'd2;
  localparam logic [3:0] M_DOT  = 4'd3;
  localparam logic [3:0] M_FRAC = 4'd4;
  localparam logic [3:0] M_STR  = 4'd5;
  localparam logic [3:0] M_ESC  = 4'd6;
  localparam logic [3:0] M_OPER = 4'd7;
  localparam logic [3:0] M_MUTE = 4'd8;

  function automatic logic [15:0] sat16(input logic [PW-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return (t > 32'd65535) ? 16'hFFFF : t[15:0];
  endfunction

  function automatic logic [7:0] sat8(input logic [LW-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return (t > 32'd255) ? 8'hFF : t[7:0];
  endfunction

  logic [3:0]    scan_mode, scan_mode_next;
  logic [7:0]    pending_operator, pending_operator_next;
  logic [63:0]   keyword_window, keyword_window_next;
  logic [LW-1:0] token_length, token_length_next;
  logic [PW-1:0] line_count, line_count_next;
  logic [PW-1:0] column_count, column_count_next;
  logic [PW-1:0] token_start_line, token_start_line_next;
  logic [PW-1:0] token_start_column, token_start_column_next;

  tok_rec_t      rec [3];
  logic [1:0]    rec_count;

  tok_rec_t      queue [QueueDepth];
  logic [QW-1:0] wr_ptr, rd_ptr;
  logic [QW:0]   fill;
  logic          accept, pop;

  assign accept = bytes.valid && bytes.ready;
  assign bytes.ready = (fill <= (QW + 1)'(QueueDepth - 3));
  assign pop = tokens.valid && tokens.ready;

  always_comb begin
    logic [7:0]    c;
    logic          done;
    logic          has;
    logic          is_let, is_dig;
    logic [5:0]    k;
    logic [PW-1:0] ln, cl;
    scan_mode_next = scan_mode;
    pending_operator_next = pending_operator;
    keyword_window_next = keyword_window;
    token_length_next = token_length;
    line_count_next = line_count;
    column_count_next = column_count;
    token_start_line_next = token_start_line;
    token_start_column_next = token_start_column;
    rec[0] = '0;
    rec[1] = '0;
    rec[2] = '0;
    rec_count = 2'd0;
    c = bytes.char_code;
    ln = line_count;
    cl = column_count;
    done = 1'b0;
    has = 1'b0;
    k = KIND_ENDFILE;
    is_let = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    is_dig = (c >= "0" && c <= "9");

    if (c != 8'd0) begin
      case (scan_mode_next)
        M_MUTE: done = 1'b1;
        M_WORD: begin
          if (is_let || is_dig || c == "_") begin
            if (token_length_next < LW'(8)) keyword_window_next = {keyword_window_next[55:0], c};
            if (token_length_next < LW'(MAX_TOKEN_LEN)) token_length_next = token_length_next + 1'b1;
            done = 1'b1;
          end
        end
        M_INT: begin
          if (is_dig || c == ".") begin
            if (c == ".") scan_mode_next = M_DOT;
            if (token_length_next < LW'(MAX_TOKEN_LEN)) token_length_next = token_length_next + 1'b1;
            done = 1'b1;
          end
        end
        M_DOT: begin
          if (is_dig) begin
            scan_mode_next = M_FRAC;
            if (token_length_next < LW'(MAX_TOKEN_LEN)) token_length_next = token_length_next + 1'b1;
          end else begin
            rec[rec_count] = '{KIND_ERROR, ERR_FLOAT, sat16(ln), sat16(cl), 8'd0, 1'b0};
            rec_count = rec_count + 2'd1;
            scan_mode_next = M_MUTE;
          end
          done = 1'b1;
        end
        M_FRAC: begin
          if (is_dig) begin
            if (token_length_next < LW'(MAX_TOKEN_LEN)) token_length_next = token_length_next + 1'b1;
            done = 1'b1;
          end
        end
        M_STR: begin
          if (c == "\"") begin
            rec[rec_count] = '{KIND_STRING, ERR_NONE, sat16(token_start_line_next),
                               sat16(token_start_column_next), sat8(token_length_next), 1'b0};
            rec_count = rec_count + 2'd1;
            scan_mode_next = M_IDLE;
          end else if (c == "\\") begin
            scan_mode_next = M_ESC;
          end else if (token_length_next < LW'(MAX_TOKEN_LEN)) begin
            token_length_next = token_length_next + 1'b1;
          end
          done = 1'b1;
        end
        M_ESC: begin
          if (c == "n" || c == "t" || c == "r" || c == "\"" || c == "\\") begin
            if (token_length_next < LW'(MAX_TOKEN_LEN)) token_length_next = token_length_next + 1'b1;
            scan_mode_next = M_STR;
          end else begin
            rec[rec_count] = '{KIND_ERROR, ERR_ESCAPE, sat16(ln), sat16(cl), 8'd0, 1'b0};
            rec_count = rec_count + 2'd1;
            scan_mode_next = M_MUTE;
          end
          done = 1'b1;
        end
        M_OPER: begin
          k = pair_kind(pending_operator_next, c);
          if (k != KIND_ENDFILE) begin
            rec[rec_count] = '{k, ERR_NONE, sat16(token_start_line_next),
                               sat16(token_start_column_next), 8'd2, 1'b0};
            rec_count = rec_count + 2'd1;
            scan_mode_next = M_IDLE;
            pending_operator_next = 8'd0;
            done = 1'b1;
          end
        end
        default: scan_mode_next = M_IDLE;
      endcase

      if (!done) begin
        has = 1'b1;
        case (scan_mode_next)
          M_WORD: k = (token_length_next > LW'(8)) ? KIND_IDENT : keyword_kind(keyword_window_next);
          M_INT: k = KIND_INT;
          M_FRAC: k = KIND_FLOAT;
          M_OPER: begin
            k = single_op_kind(pending_operator_next);
            token_length_next = LW'(1);
          end
          default: has = 1'b0;
        endcase
        if (has) begin
          rec[rec_count] = '{k, ERR_NONE, sat16(token_start_line_next),
                             sat16(token_start_column_next), sat8(token_length_next), 1'b0};
          rec_count = rec_count + 2'd1;
        end
        scan_mode_next = M_IDLE;

        token_start_line_next = ln;
        token_start_column_next = cl;
        token_length_next = '0;
        keyword_window_next = '0;
        pending_operator_next = 8'd0;
        k = KIND_ENDFILE;
        has = 1'b1;
        if (is_let) begin
          scan_mode_next = M_WORD;
          keyword_window_next = 64'(c);
          token_length_next = LW'(1);
          has = 1'b0;
        end else if (is_dig) begin
          scan_mode_next = M_INT;
          token_length_next = LW'(1);
          has = 1'b0;
        end else begin
          case (c)
            "\"": begin
              scan_mode_next = M_STR;
              has = 1'b0;
            end
            "+", "-", "=", "!", "<", ">": begin
              scan_mode_next = M_OPER;
              pending_operator_next = c;
              has = 1'b0;
            end
            " ": has = 1'b0;
            "\n": begin
              rec[rec_count] = '{KIND_NEWLINE, ERR_NONE, sat16(ln), sat16(cl), 8'd0, 1'b0};
              rec_count = rec_count + 2'd1;
              has = 1'b0;
            end
            "*": k = KIND_STAR;
            "/": k = KIND_SLASH;
            "%": k = KIND_PERCENT;
            "(": k = KIND_LPAREN;
            ")": k = KIND_RPAREN;
            "[": k = KIND_LBRACK;
            "]": k = KIND_RBRACK;
            "{": k = KIND_LBRACE;
            "}": k = KIND_RBRACE;
            ".": k = KIND_DOT;
            ",": k = KIND_COMMA;
            ":": k = KIND_COLON;
            ";": k = KIND_SEMI;
            default: begin
              rec[rec_count] = '{KIND_ERROR, ERR_UNEXPECTED, sat16(ln), sat16(cl), 8'd0, 1'b0};
              rec_count = rec_count + 2'd1;
              scan_mode_next = M_MUTE;
              has = 1'b0;
            end
          endcase
          if (has) begin
            rec[rec_count] = '{k, ERR_NONE, sat16(ln), sat16(cl), 8'd1, 1'b0};
            rec_count = rec_count + 2'd1;
          end
        end
      end

      if (c == "\n") begin
        if (line_count_next != '1) line_count_next = line_count_next + 1'b1;
        column_count_next = '0;
      end else if (column_count_next != '1) begin
        column_count_next = column_count_next + 1'b1;
      end
    end

    if (c == 8'd0 || bytes.last_byte) begin
      if (scan_mode_next == M_DOT) begin
        rec[rec_count] = '{KIND_ERROR, ERR_FLOAT, sat16(line_count_next),
                           sat16(column_count_next), 8'd0, 1'b0};
        rec_count = rec_count + 2'd1;
      end else if (scan_mode_next == M_STR || scan_mode_next == M_ESC) begin
        rec[rec_count] = '{KIND_ERROR, ERR_UNCLOSED, sat16(line_count_next),
                           sat16(column_count_next), 8'd0, 1'b0};
        rec_count = rec_count + 2'd1;
      end else if (scan_mode_next != M_MUTE) begin
        has = 1'b1;
        case (scan_mode_next)
          M_WORD: k = (token_length_next > LW'(8)) ? KIND_IDENT : keyword_kind(keyword_window_next);
          M_INT: k = KIND_INT;
          M_FRAC: k = KIND_FLOAT;
          M_OPER: begin
            k = single_op_kind(pending_operator_next);
            token_length_next = LW'(1);
          end
          default: has = 1'b0;
        endcase
        if (has) begin
          rec[rec_count] = '{k, ERR_NONE, sat16(token_start_line_next),
                             sat16(token_start_column_next), sat8(token_length_next), 1'b0};
          rec_count = rec_count + 2'd1;
        end
      end
      rec[rec_count] = '{KIND_ENDFILE, ERR_NONE, sat16(line_count_next),
                         sat16(column_count_next), 8'd0, 1'b0};
      rec_count = rec_count + 2'd1;
      scan_mode_next = M_IDLE;
      pending_operator_next = 8'd0;
      keyword_window_next = '0;
      token_length_next = '0;
      line_count_next = '0;
      column_count_next = '0;
      token_start_line_next = '0;
      token_start_column_next = '0;
    end

    if (rec_count != 2'd0) rec[rec_count - 2'd1].run_end = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= M_IDLE;
      pending_operator <= 8'd0;
      keyword_window <= '0;
      token_length <= '0;
      line_count <= '0;
      column_count <= '0;
      token_start_line <= '0;
      token_start_column <= '0;
    end else if (accept) begin
      scan_mode <= scan_mode_next;
      pending_operator <= pending_operator_next;
      keyword_window <= keyword_window_next;
      token_length <= token_length_next;
      line_count <= line_count_next;
      column_count <= column_count_next;
      token_start_line <= token_start_line_next;
      token_start_column <= token_start_column_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < rec_count) queue[wr_ptr + QW'(i)] <= rec[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + QW'(rec_count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (accept ? (QW + 1)'(rec_count) : '0) - (QW + 1)'(pop);
    end
  end

  assign tokens.valid = (fill != '0);
  assign tokens.token_kind = queue[rd_ptr].token_kind;
  assign tokens.error_code = queue[rd_ptr].error_code;
  assign tokens.start_line = queue[rd_ptr].start_line;
  assign tokens.start_column = queue[rd_ptr].start_column;
  assign tokens.value_length = queue[rd_ptr].value_length;
  assign tokens.run_end = queue[rd_ptr].run_end;

endmodule
`default_nettype wire

/* src/stt_checker.sv */
// Port-level checks on the source text tokenizer, bound to the top level.
// Depends on stt_pkg and source_text_tokenizer.
`default_nettype none
module stt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] token_kind,
  input wire logic [2:0] error_code,
  input wire logic       run_end
);
  import stt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind))
    else $error("Pending token record changed before it was taken.");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Token record offered right after reset.");

  a_error_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |-> token_kind == KIND_ERROR)
    else $error("Error code on a record that is not an error record.");

  a_endfile_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_ENDFILE |-> run_end)
    else $error("End of source record is not the last of its byte.");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (tokens.valid),
  .out_ready  (tokens.ready),
  .token_kind (tokens.token_kind),
  .error_code (tokens.error_code),
  .run_end    (tokens.run_end)
);
`default_nettype wire
